>>> sv/two_channel_led_fade_controller_defines.svh
// Assertion macros used by the fade controller checker
`ifndef TWO_CHANNEL_LED_FADE_CONTROLLER_DEFINES_SVH
`define TWO_CHANNEL_LED_FADE_CONTROLLER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge
`define FADE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("fade controller check failed: same-cycle rule");

// Next-cycle implication: when ante holds, cons holds on the following edge
`define FADE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fade controller check failed: next-cycle rule");

`endif

>>> sv/tclf_pkg.sv
// Types, operation codes and brightness curve for the LED fade controller
package tclf_pkg;

  // Operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_REAR   = 3'd1,
    OP_SET_BRAKE  = 3'd2,
    OP_BRAKE_ON   = 3'd3,
    OP_BRAKE_OFF  = 3'd4
  } op_t;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam int         CURVE_LEN = 100;

  // Per-channel fade state
  typedef struct packed {
    logic [6:0] level;
    logic [6:0] step;
    logic       pwm;
    logic       act;
  } chan_t;

  // Result of one fade step on a channel
  typedef struct packed {
    chan_t ch;
    logic  stop;
  } fade_res_t;

  // Perceptual brightness curve, percent duty per step
  localparam logic [6:0] CURVE [CURVE_LEN] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,
    7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd2,  7'd2,
    7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd3,
    7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,
    7'd6,  7'd6,  7'd6,  7'd7,  7'd7,  7'd7,  7'd8,  7'd8,  7'd9,  7'd9,
    7'd9,  7'd10, 7'd10, 7'd11, 7'd12, 7'd12, 7'd13, 7'd13, 7'd14, 7'd15,
    7'd16, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24,
    7'd25, 7'd27, 7'd28, 7'd29, 7'd31, 7'd32, 7'd34, 7'd35, 7'd37, 7'd39,
    7'd41, 7'd43, 7'd45, 7'd47, 7'd49, 7'd51, 7'd54, 7'd57, 7'd59, 7'd62,
    7'd65, 7'd68, 7'd71, 7'd75, 7'd78, 7'd82, 7'd86, 7'd90, 7'd94, 7'd100
  };

  // Curve read; past the last entry the light is fully on
  function automatic logic [6:0] curve_val(input logic [6:0] idx);
    logic [6:0] res;
    if (int'(idx) >= CURVE_LEN) begin
      res = DUTY_FULL;
    end else begin
      res = CURVE[idx];
    end
    return res;
  endfunction

endpackage

>>> sv/two_channel_led_fade_controller.sv
// Two-channel (rear and brake) LED fader: input register, step logic, state/result register
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_stall is low; the single pass of curve reads and
// compares per channel between the input register and the state registers sets that figure.
// Reset (rst_n low, synchronous): both stages empty, all levels, steps, goals, saved level,
// fade enable, PWM and activity flags cleared to zero.
module two_channel_led_fade_controller #(
  parameter int CURVE_DEPTH = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_operation,
  input  logic [6:0]            in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_rear_duty,
  output logic [6:0]            out_brake_duty,
  output logic                  out_rear_pwm_on,
  output logic                  out_brake_pwm_on,
  output logic                  out_rear_lit,
  output logic                  out_brake_lit,
  output logic                  out_fade_running
);
  import tclf_pkg::*;

  // Curve reads at or past CURVE_LIM give full duty; steps saturate at STEP_TOP
  localparam int CURVE_LIM = (CURVE_DEPTH > 128) ? 128 : CURVE_DEPTH;
  localparam int STEP_TOP  = ((CURVE_DEPTH - 1) > 127) ? 127 : (CURVE_DEPTH - 1);

  // Input stage
  logic       in_full_r, in_full_nxt;
  logic [2:0] op_r;
  logic [6:0] val_r;

  // Fade state, which also forms the result payload
  chan_t      rear_r, rear_nxt;
  chan_t      brake_r, brake_nxt;
  logic [6:0] rear_goal_r, rear_goal_nxt;
  logic [6:0] brake_goal_r, brake_goal_nxt;
  logic [6:0] saved_brake_r, saved_brake_nxt;
  logic       en_r, en_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       advance;
  logic       in_take;
  fade_res_t  rear_fade, brake_fade;

  function automatic logic [6:0] curve_at(input logic [6:0] idx);
    logic [6:0] res;
    if ({1'b0, idx} >= CURVE_LIM[7:0]) begin
      res = DUTY_FULL;
    end else begin
      res = curve_val(idx);
    end
    return res;
  endfunction

  // One tick on a channel: fade-up check, then fade-down check
  function automatic fade_res_t fade_chan(input chan_t c, input logic [6:0] goal);
    fade_res_t r;
    r.ch   = c;
    r.stop = 1'b0;
    if (c.level < goal) begin
      r.ch.level = curve_at(c.step);
      if (c.step < STEP_TOP[6:0]) begin
        r.ch.step = c.step + 7'd1;
      end
      if (r.ch.level >= goal) begin
        r.stop = 1'b1;
      end
    end
    if (r.ch.level > goal) begin
      if (r.ch.step != 7'd0) begin
        r.ch.step = r.ch.step - 7'd1;
      end
      r.ch.level = curve_at(r.ch.step);
      if (r.ch.level <= goal) begin
        r.stop = 1'b1;
        if (r.ch.level == 7'd0) begin
          r.ch.pwm = 1'b0;
          r.ch.act = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Handshake: item moves on when the result slot is free or being emptied
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign rear_fade  = fade_chan(rear_r, rear_goal_r);
  assign brake_fade = fade_chan(brake_r, brake_goal_r);

  // Stage occupancy
  always_comb begin
    in_full_nxt   = in_take || (in_full_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  // Operation decode and state update
  always_comb begin
    rear_nxt        = rear_r;
    brake_nxt       = brake_r;
    rear_goal_nxt   = rear_goal_r;
    brake_goal_nxt  = brake_goal_r;
    saved_brake_nxt = saved_brake_r;
    en_nxt          = en_r;
    if (advance) begin
      unique case (op_r)
        OP_TICK: begin
          if (en_r) begin
            rear_nxt  = rear_fade.ch;
            brake_nxt = brake_fade.ch;
            en_nxt    = !(rear_fade.stop || brake_fade.stop);
          end
        end
        OP_SET_REAR: begin
          en_nxt = 1'b1;
          if (val_r != 7'd0 && !rear_r.act) begin
            rear_nxt.pwm = 1'b1;
            rear_nxt.act = 1'b1;
          end
          rear_goal_nxt = val_r;
        end
        OP_SET_BRAKE: begin
          en_nxt = 1'b1;
          if (val_r != 7'd0) begin
            brake_nxt.pwm = 1'b1;
          end
          brake_goal_nxt = val_r;
        end
        OP_BRAKE_ON: begin
          brake_nxt.act   = 1'b1;
          saved_brake_nxt = brake_r.level;
          if (brake_r.level == 7'd0) begin
            brake_nxt.pwm = 1'b1;
          end
          brake_nxt.level = DUTY_FULL;
        end
        OP_BRAKE_OFF: begin
          brake_nxt.level = saved_brake_r;
          if (saved_brake_r == 7'd0) begin
            brake_nxt.pwm = 1'b0;
          end
          brake_nxt.act = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      rear_r        <= '0;
      brake_r       <= '0;
      rear_goal_r   <= '0;
      brake_goal_r  <= '0;
      saved_brake_r <= '0;
      en_r          <= 1'b0;
    end else begin
      in_full_r     <= in_full_nxt;
      out_valid_r   <= out_valid_nxt;
      rear_r        <= rear_nxt;
      brake_r       <= brake_nxt;
      rear_goal_r   <= rear_goal_nxt;
      brake_goal_r  <= brake_goal_nxt;
      saved_brake_r <= saved_brake_nxt;
      en_r          <= en_nxt;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_operation;
      val_r <= in_value;
    end
  end

  // State only changes as an item enters the result slot, so it is the result
  assign out_valid        = out_valid_r;
  assign out_rear_duty    = rear_r.level;
  assign out_brake_duty   = brake_r.level;
  assign out_rear_pwm_on  = rear_r.pwm;
  assign out_brake_pwm_on = brake_r.pwm;
  assign out_rear_lit     = rear_r.act;
  assign out_brake_lit    = brake_r.act;
  assign out_fade_running = en_r;

endmodule

>>> sv/tclf_checker.sv
// Port-level checker for the LED fade controller, bound to the top level
module tclf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_rear_duty,
  input logic [6:0] out_brake_duty,
  input logic       out_rear_pwm_on,
  input logic       out_rear_lit
);
`include "two_channel_led_fade_controller_defines.svh"

  // Reset empties the result slot
  `FADE_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid)

  // A stalled result stays offered
  `FADE_ASSERT_NEXT(a_hold_valid, rst_n && out_valid && out_stall, out_valid)

  // Duties never exceed full scale
  `FADE_ASSERT_NOW(a_duty_range, rst_n && out_valid,
                   out_rear_duty <= 7'd100 && out_brake_duty <= 7'd100)

  // Rear PWM and rear activity flag are set and cleared together
  `FADE_ASSERT_NOW(a_rear_flags, rst_n && out_valid, out_rear_pwm_on == out_rear_lit)

endmodule

bind two_channel_led_fade_controller tclf_checker u_tclf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rear_duty   (out_rear_duty),
  .out_brake_duty  (out_brake_duty),
  .out_rear_pwm_on (out_rear_pwm_on),
  .out_rear_lit    (out_rear_lit)
);

>>> tb/two_channel_led_fade_controller_tb.sv
// Self-checking testbench for the two-channel LED fade controller
`timescale 1ns / 1ps

import tclf_pkg::*;

// Lamp outputs after one item
typedef struct packed {
  logic [6:0] rear_duty;
  logic [6:0] brake_duty;
  logic       rear_pwm_on;
  logic       brake_pwm_on;
  logic       rear_lit;
  logic       brake_lit;
  logic       fade_running;
} lamp_view_t;

// Tracks both fade channels and holds the lamp outputs still to come
class lamp_scoreboard;
  localparam bit [6:0] LAST_STEP = 7'd99;
  localparam bit [6:0] FULL_DUTY = 7'd100;

  bit [6:0]   gamma_tab [100];
  bit [6:0]   rear_lvl, brake_lvl, rear_idx, brake_idx;
  bit [6:0]   rear_goal, brake_goal, held_brake;
  bit         fade_en, rear_pwm, brake_pwm, rear_act, brake_act;
  lamp_view_t expected_lamps [$];
  int         errors;

  function new();
    gamma_tab = '{
      0, 0, 0, 0, 0, 0, 0, 1, 1, 1,
      1, 1, 1, 1, 1, 1, 1, 1, 2, 2,
      2, 2, 2, 2, 2, 2, 3, 3, 3, 3,
      3, 4, 4, 4, 4, 4, 4, 5, 5, 5,
      6, 6, 6, 7, 7, 7, 8, 8, 9, 9,
      9, 10, 10, 11, 12, 12, 13, 13, 14, 15,
      16, 16, 17, 18, 19, 20, 21, 22, 23, 24,
      25, 27, 28, 29, 31, 32, 34, 35, 37, 39,
      41, 43, 45, 47, 49, 51, 54, 57, 59, 62,
      65, 68, 71, 75, 78, 82, 86, 90, 94, 100
    };
    errors = 0;
  endfunction

  // Brightness at a step; past the end of the curve the lamp is full on
  function bit [6:0] brightness(bit [6:0] idx);
    return (idx > LAST_STEP) ? FULL_DUTY : gamma_tab[idx];
  endfunction

  // One tick on one channel: fade-up check first, then fade-down
  function void fade_one(inout bit [6:0] lvl, inout bit [6:0] idx, input bit [6:0] goal,
                         inout bit pwm, inout bit act);
    if (lvl < goal) begin
      lvl = brightness(idx);
      if (idx < LAST_STEP) idx++;
      if (lvl >= goal) fade_en = 1'b0;
    end
    if (lvl > goal) begin
      if (idx > 0) idx--;
      lvl = brightness(idx);
      if (lvl <= goal) begin
        fade_en = 1'b0;
        if (lvl == 0) begin
          pwm = 1'b0;
          act = 1'b0;
        end
      end
    end
  endfunction

  // Advance the state by one accepted item and queue the outputs it leaves
  function void apply_item(logic [2:0] op, logic [6:0] val);
    lamp_view_t view;
    case (op)
      OP_TICK: begin
        if (fade_en) begin
          fade_one(rear_lvl, rear_idx, rear_goal, rear_pwm, rear_act);
          fade_one(brake_lvl, brake_idx, brake_goal, brake_pwm, brake_act);
        end
      end
      OP_SET_REAR: begin
        fade_en = 1'b1;
        if (val != 0 && !rear_act) begin
          rear_pwm = 1'b1;
          rear_act = 1'b1;
        end
        rear_goal = val;
      end
      OP_SET_BRAKE: begin
        fade_en = 1'b1;
        if (val != 0) brake_pwm = 1'b1;
        brake_goal = val;
      end
      OP_BRAKE_ON: begin
        brake_act  = 1'b1;
        held_brake = brake_lvl;
        if (brake_lvl == 0) brake_pwm = 1'b1;
        brake_lvl = FULL_DUTY;
      end
      OP_BRAKE_OFF: begin
        brake_lvl = held_brake;
        if (held_brake == 0) brake_pwm = 1'b0;
        brake_act = 1'b0;
      end
      default: ;
    endcase
    view.rear_duty    = rear_lvl;
    view.brake_duty   = brake_lvl;
    view.rear_pwm_on  = rear_pwm;
    view.brake_pwm_on = brake_pwm;
    view.rear_lit     = rear_act;
    view.brake_lit    = brake_act;
    view.fade_running = fade_en;
    expected_lamps.push_back(view);
  endfunction

  function void field_check(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Compare one result against the oldest expectation
  function void check_lamps(lamp_view_t got);
    lamp_view_t exp_view;
    if (expected_lamps.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp_view = expected_lamps.pop_front();
    field_check("rear_duty", exp_view.rear_duty, got.rear_duty);
    field_check("brake_duty", exp_view.brake_duty, got.brake_duty);
    field_check("rear_pwm_on", exp_view.rear_pwm_on, got.rear_pwm_on);
    field_check("brake_pwm_on", exp_view.brake_pwm_on, got.brake_pwm_on);
    field_check("rear_lit", exp_view.rear_lit, got.rear_lit);
    field_check("brake_lit", exp_view.brake_lit, got.brake_lit);
    field_check("fade_running", exp_view.fade_running, got.fade_running);
  endfunction

  function int pending();
    return expected_lamps.size();
  endfunction
endclass

module two_channel_led_fade_controller_tb;

  localparam int        ITEM_TARGET = 400;
  localparam int        LONG_HOLD   = 80;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_operation = 3'd0;
  logic [6:0] in_value = 7'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_rear_duty;
  logic [6:0] out_brake_duty;
  logic       out_rear_pwm_on;
  logic       out_brake_pwm_on;
  logic       out_rear_lit;
  logic       out_brake_lit;
  logic       out_fade_running;

  lamp_scoreboard lamps = new();

  bit hold_off_req = 1'b0;
  bit gapless = 1'b0;
  int burst_left = 0;
  int useful_items = 0;

  two_channel_led_fade_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rear_duty    (out_rear_duty),
    .out_brake_duty   (out_brake_duty),
    .out_rear_pwm_on  (out_rear_pwm_on),
    .out_brake_pwm_on (out_brake_pwm_on),
    .out_rear_lit     (out_rear_lit),
    .out_brake_lit    (out_brake_lit),
    .out_fade_running (out_fade_running)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one item, in bursts with random gaps between them
  task automatic push_item(logic [2:0] op, logic [6:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (!gapless && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    // ignored items: spare codes and ticks while the fade is stopped
    if (op <= OP_BRAKE_OFF && (op != OP_TICK || lamps.fade_en)) useful_items++;
    lamps.apply_item(op, val);
  endtask

  // Stop offering until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (lamps.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_goal();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'($urandom_range(101, 127));
      3:       return lamps.brightness(7'($urandom_range(0, 99)));
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  // Receiver: random stall phases, plus one long hold-off on request
  initial begin
    int phase_len;
    int stall_pct;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        phase_len = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        repeat (phase_len) begin
          // a hold-off request cuts the current phase short
          if (hold_off_req) break;
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    lamp_view_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.rear_duty    = out_rear_duty;
      got.brake_duty   = out_brake_duty;
      got.rear_pwm_on  = out_rear_pwm_on;
      got.brake_pwm_on = out_brake_pwm_on;
      got.rear_lit     = out_rear_lit;
      got.brake_lit    = out_brake_lit;
      got.fade_running = out_fade_running;
      lamps.check_lamps(got);
    end
  end

  // Stimulus
  initial begin
    int  n_ticks;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: disabled tick, spare codes, override from dark, extreme goals
    push_item(OP_TICK, 7'd0);
    push_item(OP_SPARE_5, 7'd127);
    push_item(OP_SPARE_7, 7'd0);
    push_item(OP_BRAKE_ON, 7'd0);
    push_item(OP_BRAKE_OFF, 7'd0);
    push_item(OP_SET_REAR, 7'd0);
    push_item(OP_TICK, 7'd0);
    push_item(OP_SET_REAR, 7'd127);
    push_item(OP_SET_BRAKE, 7'd100);
    repeat (4) push_item(OP_TICK, 7'd127);
    push_item(OP_BRAKE_ON, 7'd85);
    push_item(OP_BRAKE_ON, 7'd42);
    push_item(OP_TICK, 7'd0);
    push_item(OP_BRAKE_OFF, 7'd127);
    push_item(OP_SET_BRAKE, 7'd0);
    repeat (3) push_item(OP_TICK, 7'd0);
    // goal between two curve points
    push_item(OP_SET_REAR, 7'd26);
    push_item(OP_SPARE_6, 7'd85);
    repeat (2) push_item(OP_TICK, 7'd0);
    drain();

    // random: mostly goal changes followed by tick runs, some noise
    while (useful_items < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 1)) push_item(OP_SET_REAR, pick_goal());
        if ($urandom_range(0, 1)) push_item(OP_SET_BRAKE, pick_goal());
        n_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 110)
                                              : $urandom_range(1, 25);
        repeat (n_ticks) begin
          if (!lamps.fade_en && $urandom_range(0, 3) != 0) break;
          if ($urandom_range(0, 29) == 0)
            push_item($urandom_range(0, 1) ? OP_BRAKE_ON : OP_BRAKE_OFF,
                      7'($urandom_range(0, 127)));
          push_item(OP_TICK, 7'($urandom_range(0, 127)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          push_item(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 15) == 0) drain();
      // long receiver hold-off while items keep coming, then a full drain
      if (!hold_done && useful_items > ITEM_TARGET / 2) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        gapless = 1'b1;
        push_item(OP_SET_REAR, pick_goal());
        repeat (24) push_item(OP_TICK, 7'($urandom_range(0, 127)));
        gapless = 1'b0;
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (lamps.errors == 0 && lamps.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
